// ----- rtl/rvq_pkg.sv -----
package rvq_pkg;

  localparam int unsigned RW        = 32;
  localparam int unsigned N28W      = 32;
  localparam int unsigned XW        = 34;
  localparam int unsigned ZW        = 32;
  localparam int unsigned QW        = 31;
  localparam int unsigned KW        = 4;
  localparam int unsigned KMAX      = 11;
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 30;

  localparam logic [33:0] HALF_PI    = 34'd1686629713;
  localparam logic [33:0] QUARTER_PI = 34'd843314856;
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032875;
  localparam logic signed [63:0] OUT_MAX = 64'sd536870912;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

  typedef struct packed {
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
    logic signed [RW-1:0] rz;
  } vec_t;

  typedef struct packed {
    logic            tiny;
    logic [N28W-1:0] n28;
    vec_t            r;
  } cord_side_t;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic                 tiny;
    vec_t                 r;
  } div_side_t;

  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [37:0] half_pi_mult(input logic [KW-1:0] k);
    return 38'(k) * 38'(HALF_PI);
  endfunction

  function automatic logic signed [QW-1:0] clamp31(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > OUT_MAX) c = OUT_MAX;
    else if (v < -OUT_MAX) c = -OUT_MAX;
    else c = v;
    return c[QW-1:0];
  endfunction

endpackage

// ----- rtl/rvq_isqrt.sv -----
module rvq_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [63:0]           radicand_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [31:0]           root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned N = rvq_pkg::SQ_STEPS;

  logic [63:0]       rem_q  [N];
  logic [63:0]       root_q [N];
  logic [SIDE_W-1:0] side_q [N];
  logic [N-1:0]      vld_q;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (2 * (N - 1 - j));
    logic [63:0]       rem_in, root_in, trial, rem_d, root_d;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (j == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    always_comb begin
      trial = root_in + Bit;
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + Bit;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1][31:0];
  assign side_o  = side_q[N-1];

endmodule

// ----- rtl/rvq_cordic.sv -----
module rvq_cordic #(
  parameter int unsigned STEPS  = 24,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [rvq_pkg::N28W-1:0]       n28_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic signed [rvq_pkg::XW-1:0]  cos_o,
  output logic signed [rvq_pkg::XW-1:0]  sin_o,
  output logic [SIDE_W-1:0]              side_o
);

  localparam int unsigned XW = rvq_pkg::XW;
  localparam int unsigned ZW = rvq_pkg::ZW;
  localparam int unsigned KW = rvq_pkg::KW;

  // quadrant count
  logic [33:0]       a_q;
  logic [KW-1:0]     k_q, k_d;
  logic [SIDE_W-1:0] sk_q;
  logic              vk_q;
  logic [34:0]       asum;

  always_comb begin
    asum = 35'({n28_i, 2'b00}) + 35'(rvq_pkg::QUARTER_PI);
    k_d  = '0;
    for (int m = 1; m <= int'(rvq_pkg::KMAX); m++) begin
      if (asum >= 35'(64'(m) * 64'(rvq_pkg::HALF_PI))) k_d = KW'(m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q <= 1'b0;
    end else if (en_i) begin
      vk_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= {n28_i, 2'b00};
      k_q  <= k_d;
      sk_q <= side_i;
    end
  end

  // rotation stages; index 0 holds the reduced angle
  logic signed [XW-1:0] x_q [STEPS+1];
  logic signed [XW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];
  logic [1:0]           quad_q [STEPS+1];
  logic [SIDE_W-1:0]    s_q [STEPS+1];
  logic [STEPS:0]       v_q;
  logic signed [38:0]   zr;

  assign zr = $signed({5'd0, a_q}) - $signed({1'b0, rvq_pkg::half_pi_mult(k_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= vk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= rvq_pkg::GAIN_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= zr[ZW-1:0];
      quad_q[0] <= k_q[1:0];
      s_q[0]    <= sk_q;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] Atan = $signed(rvq_pkg::atan_q30(i));
    logic signed [XW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
      if (!z_q[i][ZW-1]) begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - Atan;
      end else begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + Atan;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        quad_q[i+1] <= quad_q[i];
        s_q[i+1]    <= s_q[i];
      end
    end
  end

  // quadrant map
  logic signed [XW-1:0] c_d, s_d, xl, yl;
  logic                 vo_q;

  assign xl = x_q[STEPS];
  assign yl = y_q[STEPS];

  always_comb begin
    case (quad_q[STEPS])
      2'd0: begin
        c_d = xl;
        s_d = yl;
      end
      2'd1: begin
        c_d = -yl;
        s_d = xl;
      end
      2'd2: begin
        c_d = -xl;
        s_d = -yl;
      end
      default: begin
        c_d = yl;
        s_d = -xl;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o  <= c_d;
      sin_o  <= s_d;
      side_o <= s_q[STEPS];
    end
  end

  assign valid_o = vo_q;

endmodule

// ----- rtl/rvq_div.sv -----
module rvq_div #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [63:0]             num_i [3],
  input  logic [rvq_pkg::N28W-1:0]       n28_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic signed [rvq_pkg::QW-1:0]  quot_o [3],
  output logic [SIDE_W-1:0]              side_o
);

  localparam int unsigned N  = rvq_pkg::DIV_STEPS;
  localparam int unsigned QW = rvq_pkg::QW;

  // per stage: remainder, quotient bits, sign, overflow
  logic [63:0]       rem_q [N+1][3];
  logic [N-1:0]      q_q   [N+1][3];
  logic              neg_q [N+1][3];
  logic              ovf_q [N+1][3];
  logic [32:0]       den_q [N+1];
  logic [SIDE_W-1:0] s_q   [N+1];
  logic [N:0]        v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= {n28_i, 1'b0};
      s_q[0]   <= side_i;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic        neg;
    logic [63:0] mag, dvd;

    always_comb begin
      neg = num_i[l][63];
      mag = neg ? 64'(-num_i[l]) : 64'(num_i[l]);
      dvd = mag + 64'(n28_i);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l] <= dvd;
        q_q[0][l]   <= '0;
        neg_q[0][l] <= neg;
        ovf_q[0][l] <= (dvd >> N) >= 64'({n28_i, 1'b0});
      end
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int unsigned B = N - 1 - j;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j+1] <= den_q[j];
        s_q[j+1]   <= s_q[j];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [63:0] sub;
      logic        ge;

      always_comb begin
        sub = 64'(den_q[j]) << B;
        ge  = rem_q[j][l] >= sub;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1][l] <= ge ? rem_q[j][l] - sub : rem_q[j][l];
          q_q[j+1][l]   <= q_q[j][l] | (N'(ge) << B);
          neg_q[j+1][l] <= neg_q[j][l];
          ovf_q[j+1][l] <= ovf_q[j][l];
        end
      end
    end
  end

  logic vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= s_q[N];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic signed [QW-1:0] mg;

    always_comb begin
      if (ovf_q[N][l] || 64'(q_q[N][l]) > 64'(rvq_pkg::OUT_MAX)) begin
        mg = rvq_pkg::OUT_MAX[QW-1:0];
      end else begin
        mg = QW'(q_q[N][l]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_o[l] <= neg_q[N][l] ? -mg : mg;
      end
    end
  end

  assign valid_o = vo_q;

endmodule

// ----- rtl/rotation_vector_to_quaternion_core.sv -----
// Rotation vector to unit quaternion, fully pipelined.
// Stages on the path from input accept to output valid:
// 32 square-root stages, CORDIC_STEPS rotation stages, 30 divider stages.
// Throughput: one item per cycle; a stall on the output freezes the whole pipe.
// Reset clears all valid bits and sets small_angle_threshold to 1.
module rotation_vector_to_quaternion_core #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // rot_x, rot_y, rot_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z, zero pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned QW = rvq_pkg::QW;
  localparam int unsigned XW = rvq_pkg::XW;

  logic en;
  logic [7:0] thr_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rvq_pkg::ADDR_THRESHOLD[2]) ? {24'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 8'd1;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == rvq_pkg::ADDR_THRESHOLD[2]) begin
      thr_q <= pwdata[7:0];
    end
  end

  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = m_valid_q;

  // squares
  rvq_pkg::vec_t    rin, ra_q, rb_q;
  logic [63:0]      sq_q [3];
  logic [63:0]      sum_q;
  logic             va_q, vb_q;

  assign rin.rx = s_axis_tdata[31:0];
  assign rin.ry = s_axis_tdata[63:32];
  assign rin.rz = s_axis_tdata[95:64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q     <= rin;
      sq_q[0]  <= 64'(64'(rin.rx) * 64'(rin.rx));
      sq_q[1]  <= 64'(64'(rin.ry) * 64'(rin.ry));
      sq_q[2]  <= 64'(64'(rin.rz) * 64'(rin.rz));
      rb_q     <= ra_q;
      sum_q    <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // norm
  logic                 vs;
  logic [31:0]          n28;
  rvq_pkg::vec_t        rs;
  rvq_pkg::cord_side_t  cs_in, cs_out;

  rvq_isqrt #(
    .SIDE_W ($bits(rvq_pkg::vec_t))
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vb_q),
    .radicand_i (sum_q),
    .side_i     (rb_q),
    .valid_o    (vs),
    .root_o     (n28),
    .side_o     (rs)
  );

  assign cs_in.tiny = (n28 == '0) || ((n28 >> 1) < 32'(thr_q));
  assign cs_in.n28  = n28;
  assign cs_in.r    = rs;

  // sine and cosine
  logic                 vc;
  logic signed [XW-1:0] cosv, sinv;

  rvq_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W ($bits(rvq_pkg::cord_side_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .n28_i   (n28),
    .side_i  (cs_in),
    .valid_o (vc),
    .cos_o   (cosv),
    .sin_o   (sinv),
    .side_o  (cs_out)
  );

  // products and scalar part
  logic signed [63:0]   num_q [3];
  logic [31:0]          np_q;
  logic                 vp_q;
  rvq_pkg::div_side_t   dp_q, ds_out;
  logic signed [XW:0]   wsum;
  logic signed [XW:0]   wsh;

  assign wsum = (XW+1)'(cosv) + (XW+1)'(1);
  assign wsh  = wsum >>> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= vc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q[0]  <= 64'(66'(cs_out.r.rx) * 66'(sinv));
      num_q[1]  <= 64'(66'(cs_out.r.ry) * 66'(sinv));
      num_q[2]  <= 64'(66'(cs_out.r.rz) * 66'(sinv));
      np_q      <= cs_out.n28;
      dp_q.w    <= rvq_pkg::clamp31(64'(wsh));
      dp_q.tiny <= cs_out.tiny;
      dp_q.r    <= cs_out.r;
    end
  end

  // vector part
  logic                 vd;
  logic signed [QW-1:0] quot [3];

  rvq_div #(
    .SIDE_W ($bits(rvq_pkg::div_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp_q),
    .num_i   (num_q),
    .n28_i   (np_q),
    .side_i  (dp_q),
    .valid_o (vd),
    .quot_o  (quot),
    .side_o  (ds_out)
  );

  logic signed [QW-1:0] qx, qy, qz;
  logic [127:0]         tdata_q;

  assign qx = ds_out.tiny ? rvq_pkg::clamp31(64'($signed({ds_out.r.rx, 1'b0}))) : quot[0];
  assign qy = ds_out.tiny ? rvq_pkg::clamp31(64'($signed({ds_out.r.ry, 1'b0}))) : quot[1];
  assign qz = ds_out.tiny ? rvq_pkg::clamp31(64'($signed({ds_out.r.rz, 1'b0}))) : quot[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {4'd0, qz, qy, qx, ds_out.w};
    end
  end

  assign m_axis_tdata = tdata_q;

endmodule

// ----- rtl/rvq_checker.sv -----
module rvq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[30:0]) <= 31'sd536870912
                   && $signed(m_axis_tdata[30:0]) >= -31'sd536870912)
    else $error("quat_w out of range");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[127:124] == 4'd0)
    else $error("pad bits not zero");

endmodule

bind rotation_vector_to_quaternion_core rvq_checker u_rvq_checker (.*);

// ----- tb/rvq_quat_checker.sv -----
module rvq_quat_checker #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [95:0]  s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [127:0] m_tdata_i,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic         pready_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic signed [30:0] w;
    logic signed [30:0] x;
    logic signed [30:0] y;
    logic signed [30:0] z;
  } quat_t;

  localparam longint ANGLE_HALF_PI = 64'sd1686629713;
  localparam longint ANGLE_QTR_PI  = 64'sd843314856;
  localparam longint CORDIC_GAIN   = 64'sd652032875;
  localparam longint QUAT_ONE      = 64'sd536870912;

  localparam longint ARCTAN_Q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  logic [7:0] small_thresh;
  quat_t      expected_quats [$];

  function automatic logic signed [30:0] sat_q229(longint v);
    longint c;
    if (v > QUAT_ONE) c = QUAT_ONE;
    else if (v < -QUAT_ONE) c = -QUAT_ONE;
    else c = v;
    return c[30:0];
  endfunction

  function automatic quat_t predict_quaternion(logic [95:0] d, logic [7:0] thr);
    longint               r [3];
    longint unsigned      sum, rem, root, bitv;
    longint               n28, ang, k, z, x, y, t, c, s, num, q, den;
    longint unsigned      mag;
    logic signed [30:0]   v [3];
    quat_t                res;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'($signed(d[32*i +: 32]));
      sum += longint'(r[i] * r[i]);
    end
    rem = sum;
    root = 0;
    for (int j = 31; j >= 0; j--) begin
      bitv = 64'd1 << (2 * j);
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
    end
    n28 = longint'(root);
    ang = n28 << 2;
    k = (ang + ANGLE_QTR_PI) / ANGLE_HALF_PI;
    z = ang - k * ANGLE_HALF_PI;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN_Q30[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN_Q30[i];
      end
      x = t;
    end
    case (k & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    res.w = sat_q229((c + 1) >>> 1);
    for (int i = 0; i < 3; i++) begin
      if (n28 == 0 || (n28 >> 1) < longint'(thr)) begin
        v[i] = sat_q229(r[i] * 2);
      end else begin
        den = 2 * n28;
        num = r[i] * s;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = longint'((mag + longint'(den / 2)) / longint'(den));
        if (q > QUAT_ONE) q = QUAT_ONE;
        v[i] = sat_q229((num < 0) ? -q : q);
      end
    end
    res.x = v[0];
    res.y = v[1];
    res.z = v[2];
    return res;
  endfunction

  function automatic int field_bad(string name, logic signed [30:0] e, logic signed [30:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      return 1;
    end
    return 0;
  endfunction

  assign pending_o = expected_quats.size();

  always @(posedge clk_i or negedge rst_ni) begin
    quat_t exp_q, got;
    int    bad;
    if (!rst_ni) begin
      small_thresh <= 8'd1;
      fail_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i
          && paddr_i[2] == rvq_pkg::ADDR_THRESHOLD[2])
        small_thresh <= pwdata_i[7:0];
      if (s_tvalid_i && s_tready_i)
        expected_quats.push_back(predict_quaternion(s_tdata_i, small_thresh));
      if (m_tvalid_i && m_tready_i) begin
        got.w = m_tdata_i[30:0];
        got.x = m_tdata_i[61:31];
        got.y = m_tdata_i[92:62];
        got.z = m_tdata_i[123:93];
        if (expected_quats.size() == 0) begin
          $error("quaternion item with no expectation waiting");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_q = expected_quats.pop_front();
          bad = field_bad("quat_w", exp_q.w, got.w) + field_bad("quat_x", exp_q.x, got.x)
              + field_bad("quat_y", exp_q.y, got.y) + field_bad("quat_z", exp_q.z, got.z);
          if (bad != 0) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

// ----- tb/tb_rotation_vector_to_quaternion_core.sv -----
module tb_rotation_vector_to_quaternion_core;

  localparam int unsigned STEPS      = 24;
  localparam int          DRAIN_WAIT = STEPS + 100;
  localparam int          STALL_MAX  = 4000;
  localparam logic [31:0] HALF_PI_H  = 32'd421657428;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // rot_x, rot_y, rot_z
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // quat_w, quat_x, quat_y, quat_z, zero pad
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int   fail_count, pending, idle_cycles;
  logic no_gaps = 1'b0;
  logic [7:0] thresh_now = 8'd1;

  rotation_vector_to_quaternion_core #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rvq_quat_checker #(.CORDIC_STEPS(STEPS)) i_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int w;
    @(posedge clk_i);
    forever begin
      w = no_gaps ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_rot(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 10);
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rz, ry, rx};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic write_thresh(logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= rvq_pkg::ADDR_THRESHOLD;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thresh_now = val[7:0];
  endtask

  function automatic logic [31:0] near_thresh_val();
    int span;
    span = 2 * int'(thresh_now) + 40;
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic send_directed();
    send_rot(0, 0, 0);
    send_rot(1, 0, 0);
    send_rot(-1, 0, 0);
    send_rot(0, 3, 0);
    send_rot(0, 0, -4);
    send_rot(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_rot(32'h80000000, 32'h80000000, 32'h80000000);
    send_rot(32'h7FFFFFFF, 0, 0);
    send_rot(0, 32'h80000000, 0);
    send_rot(0, 0, 32'h7FFFFFFF);
    send_rot(HALF_PI_H, 0, 0);
    send_rot(0, -HALF_PI_H, 0);
    send_rot(0, 0, 2 * HALF_PI_H);
    send_rot(3 * HALF_PI_H, 0, 0);
    send_rot(4 * HALF_PI_H, 0, 0);
    send_rot(2 * int'(thresh_now), 0, 0);
    send_rot(2 * int'(thresh_now) + 2, 0, 0);
    send_rot(100, -200, 300);
    send_rot(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F);
    send_rot(32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0);
  endtask

  task automatic send_random(int n);
    logic [31:0] v [3];
    int mode;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        case (mode)
          0, 1: v[a] = $urandom;
          2, 3, 4: v[a] = near_thresh_val();
          9: v[a] = (a == 0) ? ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000)
                             : near_thresh_val();
          default: v[a] = 32'($signed($urandom) >>> $urandom_range(2, 8));
        endcase
      end
      send_rot(v[0], v[1], v[2]);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    send_random(180);
    write_thresh(32'd0);
    send_directed();
    send_random(180);
    write_thresh(32'hFFFFFFFF);
    send_directed();
    send_random(180);
    write_thresh($urandom);
    send_directed();
    send_random(180);
    write_thresh(32'd1);
    send_random(50);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rvq_pkg.sv
rtl/rvq_isqrt.sv
rtl/rvq_cordic.sv
rtl/rvq_div.sv
rtl/rotation_vector_to_quaternion_core.sv
rtl/rvq_checker.sv
tb/rvq_quat_checker.sv
tb/tb_rotation_vector_to_quaternion_core.sv
